/* rtl/core/tfva_pkg.sv */
// ----------------------------------------------------------------------------
// Triangle fan vertex assembly package
// Shared widths, codes, payload types and controller/datapath link types.
// ----------------------------------------------------------------------------
package tfva_pkg;

  // Field widths fixed by the item formats.
  localparam int COORD_WIDTH = 24;
  localparam int IDX_WIDTH   = 13;

  // Default sizes handed to the top level.
  localparam int DEF_MAX_VERTICES = 4096;
  localparam int DEF_MAX_CORNERS  = 16;

  // A triangle is three vertices.
  localparam int VERTS_PER_TRI = 3;

  // Input command codes; the fourth code is ignored.
  typedef enum logic [1:0] {
    CMD_POSITION = 2'd0,
    CMD_NORMAL   = 2'd1,
    CMD_CORNER   = 2'd2
  } cmd_e;

  // Which corner the next store read belongs to.
  typedef enum logic [1:0] {
    SEL_FIRST = 2'd0,
    SEL_MID   = 2'd1,
    SEL_CUR   = 2'd2
  } rd_sel_e;

  // Controller states.
  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EMIT = 1'b1
  } fsm_state_e;

  // One input item.
  typedef struct packed {
    logic [1:0]                    cmd;
    logic                          face_start;
    logic signed [COORD_WIDTH-1:0] coord_x;
    logic signed [COORD_WIDTH-1:0] coord_y;
    logic signed [COORD_WIDTH-1:0] coord_z;
    logic [IDX_WIDTH-1:0]          pos_index;
    logic [IDX_WIDTH-1:0]          nrm_index;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] vert_x;
    logic signed [COORD_WIDTH-1:0] vert_y;
    logic signed [COORD_WIDTH-1:0] vert_z;
    logic signed [COORD_WIDTH-1:0] norm_x;
    logic signed [COORD_WIDTH-1:0] norm_y;
    logic signed [COORD_WIDTH-1:0] norm_z;
    logic                          last_of_triangle;
    logic                          index_error;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    accept;
    logic    rd_en;
    rd_sel_e rd_sel;
    logic    load_out;
    logic    last;
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic emit;
    logic out_free;
  } dp_status_t;

endpackage

/* rtl/core/tfva_ctrl.sv */
// ----------------------------------------------------------------------------
// Triangle fan vertex assembly controller
// Accepts items and sequences the three store reads of an emitting corner.
// ----------------------------------------------------------------------------
module tfva_ctrl import tfva_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  dp_status_t status_i,
  output ctl_cmd_t   cmd_o
);

  localparam logic [1:0] LAST_VERT = 2'(VERTS_PER_TRI - 1);

  fsm_state_e state_q, state_d;
  logic [1:0] vidx_q, vidx_d;
  logic       accept;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;

  // Next state and vertex counter.
  always_comb begin
    state_d = state_q;
    vidx_d  = vidx_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && status_i.emit) begin
          state_d = ST_EMIT;
          vidx_d  = '0;
        end
      end
      ST_EMIT: begin
        if (status_i.out_free) begin
          if (vidx_q == LAST_VERT) begin
            state_d = ST_IDLE;
          end else begin
            vidx_d = vidx_q + 2'd1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Datapath commands.
  always_comb begin
    cmd_o          = '0;
    cmd_o.accept   = accept;
    cmd_o.rd_sel   = SEL_FIRST;
    case (state_q)
      ST_IDLE: begin
        if (accept && status_i.emit) begin
          cmd_o.rd_en = 1'b1;
        end
      end
      ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          cmd_o.last     = (vidx_q == LAST_VERT);
          if (vidx_q != LAST_VERT) begin
            cmd_o.rd_en  = 1'b1;
            cmd_o.rd_sel = (vidx_q == 2'd0) ? SEL_MID : SEL_CUR;
          end
        end
      end
      default: begin
        cmd_o.rd_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      vidx_q  <= '0;
    end else begin
      state_q <= state_d;
      vidx_q  <= vidx_d;
    end
  end

endmodule

/* rtl/core/tfva_datapath.sv */
// ----------------------------------------------------------------------------
// Triangle fan vertex assembly datapath
// Position and normal stores, face state, index checks and output register.
// ----------------------------------------------------------------------------
module tfva_datapath import tfva_pkg::*; #(
  parameter int MAX_VERTICES = DEF_MAX_VERTICES,
  parameter int MAX_CORNERS  = DEF_MAX_CORNERS
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  in_item_t   in_i,
  input  ctl_cmd_t   cmd_i,
  output dp_status_t status_o,
  input  logic       out_stall_i,
  output logic       out_valid_o,
  output out_item_t  out_o
);

  localparam int AW   = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int CW   = $clog2(MAX_VERTICES + 1);
  localparam int KW   = $clog2(MAX_CORNERS + 1);
  localparam int CMPW = (CW > IDX_WIDTH) ? CW : IDX_WIDTH;
  localparam int DW   = 3 * COORD_WIDTH;

  // Stores, one entry holds x, y and z.
  logic [DW-1:0] pos_mem [MAX_VERTICES];
  logic [DW-1:0] nrm_mem [MAX_VERTICES];

  logic [CW-1:0]        pos_count_q, nrm_count_q;
  logic [KW-1:0]        corner_count_q;
  logic [IDX_WIDTH-1:0] first_pos_q, first_nrm_q, prev_pos_q, prev_nrm_q;
  logic [IDX_WIDTH-1:0] mid_pos_q, mid_nrm_q, cur_pos_q, cur_nrm_q;

  logic [DW-1:0] pos_rd_q, nrm_rd_q;
  logic          rd_pos_ok_q, rd_nrm_ok_q, rd_err_q;

  logic          out_valid_q;
  out_item_t     out_q, out_d;

  logic [KW-1:0]        eff_count;
  logic                 is_corner, corner_live;
  logic                 pos_we, nrm_we;
  logic [IDX_WIDTH-1:0] rd_pos_idx, rd_nrm_idx;
  logic                 pos_ok, nrm_present, nrm_ok;

  // Corner bookkeeping: a face start restarts the count.
  assign is_corner   = (in_i.cmd == CMD_CORNER);
  assign eff_count   = in_i.face_start ? '0 : corner_count_q;
  assign corner_live = is_corner && (eff_count < KW'(MAX_CORNERS));

  assign status_o.emit     = corner_live && (eff_count >= KW'(2));
  assign status_o.out_free = !out_valid_q || !out_stall_i;

  assign pos_we = cmd_i.accept && (in_i.cmd == CMD_POSITION) &&
                  (pos_count_q < CW'(MAX_VERTICES));
  assign nrm_we = cmd_i.accept && (in_i.cmd == CMD_NORMAL) &&
                  (nrm_count_q < CW'(MAX_VERTICES));

  // Face and count state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_count_q    <= '0;
      nrm_count_q    <= '0;
      corner_count_q <= '0;
      first_pos_q    <= '0;
      first_nrm_q    <= '0;
      prev_pos_q     <= '0;
      prev_nrm_q     <= '0;
    end else begin
      if (pos_we) begin
        pos_count_q <= pos_count_q + CW'(1);
      end
      if (nrm_we) begin
        nrm_count_q <= nrm_count_q + CW'(1);
      end
      if (cmd_i.accept && corner_live) begin
        if (eff_count == '0) begin
          first_pos_q <= in_i.pos_index;
          first_nrm_q <= in_i.nrm_index;
        end
        prev_pos_q     <= in_i.pos_index;
        prev_nrm_q     <= in_i.nrm_index;
        corner_count_q <= eff_count + KW'(1);
      end
    end
  end

  // Corners of the triangle in flight, captured when the corner is accepted.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && is_corner) begin
      mid_pos_q <= prev_pos_q;
      mid_nrm_q <= prev_nrm_q;
      cur_pos_q <= in_i.pos_index;
      cur_nrm_q <= in_i.nrm_index;
    end
  end

  // Read index selection and range checks.
  always_comb begin
    case (cmd_i.rd_sel)
      SEL_FIRST: begin
        rd_pos_idx = first_pos_q;
        rd_nrm_idx = first_nrm_q;
      end
      SEL_MID: begin
        rd_pos_idx = mid_pos_q;
        rd_nrm_idx = mid_nrm_q;
      end
      default: begin
        rd_pos_idx = cur_pos_q;
        rd_nrm_idx = cur_nrm_q;
      end
    endcase
  end

  assign pos_ok      = (rd_pos_idx != '0) && (CMPW'(rd_pos_idx) <= CMPW'(pos_count_q));
  assign nrm_present = (rd_nrm_idx != '0);
  assign nrm_ok      = nrm_present && (CMPW'(rd_nrm_idx) <= CMPW'(nrm_count_q));

  // Position store: appends at the count, one registered read port.
  always_ff @(posedge clk_i) begin
    if (pos_we) begin
      pos_mem[AW'(pos_count_q)] <= {in_i.coord_x, in_i.coord_y, in_i.coord_z};
    end
    if (cmd_i.rd_en) begin
      pos_rd_q <= pos_mem[AW'(rd_pos_idx - IDX_WIDTH'(1))];
    end
  end

  // Normal store: appends at the count, one registered read port.
  always_ff @(posedge clk_i) begin
    if (nrm_we) begin
      nrm_mem[AW'(nrm_count_q)] <= {in_i.coord_x, in_i.coord_y, in_i.coord_z};
    end
    if (cmd_i.rd_en) begin
      nrm_rd_q <= nrm_mem[AW'(rd_nrm_idx - IDX_WIDTH'(1))];
    end
  end

  // Check results travel alongside the read data.
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rd_pos_ok_q <= pos_ok;
      rd_nrm_ok_q <= nrm_ok;
      rd_err_q    <= !pos_ok || (nrm_present && !nrm_ok);
    end
  end

  // Vertex assembly: out-of-range or absent entries read as zero.
  always_comb begin
    out_d = '0;
    if (rd_pos_ok_q) begin
      out_d.vert_x = pos_rd_q[DW-1 -: COORD_WIDTH];
      out_d.vert_y = pos_rd_q[2*COORD_WIDTH-1 -: COORD_WIDTH];
      out_d.vert_z = pos_rd_q[COORD_WIDTH-1:0];
    end
    if (rd_nrm_ok_q) begin
      out_d.norm_x = nrm_rd_q[DW-1 -: COORD_WIDTH];
      out_d.norm_y = nrm_rd_q[2*COORD_WIDTH-1 -: COORD_WIDTH];
      out_d.norm_z = nrm_rd_q[COORD_WIDTH-1:0];
    end
    out_d.last_of_triangle = cmd_i.last;
    out_d.index_error      = rd_err_q;
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

/* rtl/core/triangle_fan_vertex_assembly.sv */
// The first vertex of a triangle is read into the store read registers with its corner
// transfer and then loaded into the output register. An append or a non-emitting corner
// is taken without a stall; an emitting corner stalls the input while its three vertices
// are read, one store read per vertex through each store's port, and while a loaded
// vertex waits on out_stall_i while the next vertex is due.
// Reset clears the store counts and face state; store contents are not cleared.
// ----------------------------------------------------------------------------
// Triangle fan vertex assembly
// Appends position and normal records and fan-triangulates face corners.
// ----------------------------------------------------------------------------
module triangle_fan_vertex_assembly import tfva_pkg::*; #(
  parameter int MAX_VERTICES = DEF_MAX_VERTICES,
  parameter int MAX_CORNERS  = DEF_MAX_CORNERS
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_o
);

  ctl_cmd_t   ctl_cmd;
  dp_status_t dp_status;

  // Sequencing of transfers and store reads.
  tfva_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (dp_status),
    .cmd_o      (ctl_cmd)
  );

  // Stores, face state and output register.
  tfva_datapath #(
    .MAX_VERTICES (MAX_VERTICES),
    .MAX_CORNERS  (MAX_CORNERS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cmd_i       (ctl_cmd),
    .status_o    (dp_status),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_o       (out_o)
  );

endmodule

/* sim/tb_triangle_fan_vertex_assembly.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle fan vertex assembly testbench
// Feeds appends and face corners through the valid/stall input channel and
// checks every emitted vertex against an in-bench fan triangulator that keeps
// its own copy of both stores and of the face state. The stimulus covers
// directed index edge cases, random faces with interleaved appends, a long
// output hold, and indices at the top of the range.
// ----------------------------------------------------------------------------
module tb_triangle_fan_vertex_assembly;
  import tfva_pkg::*;

  localparam int          CLK_PERIOD     = 10;
  localparam int          MAX_V          = DEF_MAX_VERTICES;
  localparam int          MAX_C          = DEF_MAX_CORNERS;
  localparam int          RANDOM_ITEMS   = 125;
  localparam int          LONG_HOLD      = 150;
  localparam int          DRAIN_CYCLES   = 20;
  localparam int          TIMEOUT_CYCLES = 200000;
  localparam int          PRINT_LIMIT    = 100;
  localparam logic [1:0]  CMD_UNUSED     = 2'd3;

  localparam logic [COORD_WIDTH-1:0] COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic [COORD_WIDTH-1:0] COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  // One queued input transfer with its pacing controls.
  typedef struct {
    in_item_t    item;
    int unsigned max_gap;
    bit          wait_drain;
    bit          hold_rx;
  } feed_entry_t;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  in_item_t  in_i        = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_o;

  triangle_fan_vertex_assembly #(
    .MAX_VERTICES(MAX_V),
    .MAX_CORNERS (MAX_C)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_i       (in_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_o      (out_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Shadow stores and face state of the triangulator.
  logic [3*COORD_WIDTH-1:0] pos_mem [MAX_V];
  logic [3*COORD_WIDTH-1:0] nrm_mem [MAX_V];
  int unsigned pos_count   = 0;
  int unsigned nrm_count   = 0;
  int unsigned corner_cnt  = 0;
  int unsigned first_p     = 0;
  int unsigned first_n     = 0;
  int unsigned prev_p      = 0;
  int unsigned prev_n      = 0;

  out_item_t   pending_vertices [$];
  feed_entry_t item_feed_q [$];

  // Handshake bookkeeping shared between the edge processes.
  bit          tx_busy     = 1'b0;
  bit          tx_taken    = 1'b0;
  int unsigned tx_gap      = 0;
  feed_entry_t tx_cur;
  bit          rx_taken    = 1'b0;
  bit          rx_calm     = 1'b0;
  int unsigned rx_wait     = 0;
  bit          hold_req    = 1'b0;
  int unsigned hold_left   = 0;

  int unsigned fail_count       = 0;
  int unsigned items_taken      = 0;
  int unsigned vertices_checked = 0;
  int unsigned stall_cycles     = 0;

  // Generator-side view of the store counts, used to aim indices.
  int unsigned gen_pos     = 0;
  int unsigned gen_nrm     = 0;
  int unsigned gen_corner  = 0;
  int unsigned gen_counted = 0;

  task automatic report_mismatch(input string msg);
    fail_count++;
    if (fail_count <= PRINT_LIMIT) $display("MISMATCH @%0t: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input int unsigned idx,
                             input logic [COORD_WIDTH-1:0] got,
                             input logic [COORD_WIDTH-1:0] want);
    if (got !== want)
      report_mismatch($sformatf("vertex %0d %s got %h want %h", idx, name, got, want));
  endtask

  // Builds one vertex from the stores, flagging out-of-range indices.
  function automatic out_item_t lookup_vertex(int unsigned p, int unsigned n, bit last);
    out_item_t v;
    v = '0;
    if (p == 0 || p > pos_count) v.index_error = 1'b1;
    else {v.vert_x, v.vert_y, v.vert_z} = pos_mem[p-1];
    if (n != 0) begin
      if (n > nrm_count) v.index_error = 1'b1;
      else {v.norm_x, v.norm_y, v.norm_z} = nrm_mem[n-1];
    end
    v.last_of_triangle = last;
    return v;
  endfunction

  // Applies one accepted transfer and queues the vertices it emits.
  task automatic assemble_item(input in_item_t it);
    case (it.cmd)
      CMD_POSITION: begin
        if (pos_count < MAX_V) begin
          pos_mem[pos_count] = {it.coord_x, it.coord_y, it.coord_z};
          pos_count++;
        end
      end
      CMD_NORMAL: begin
        if (nrm_count < MAX_V) begin
          nrm_mem[nrm_count] = {it.coord_x, it.coord_y, it.coord_z};
          nrm_count++;
        end
      end
      CMD_CORNER: begin
        if (it.face_start) corner_cnt = 0;
        if (corner_cnt < MAX_C) begin
          if (corner_cnt == 0) begin
            first_p = it.pos_index;
            first_n = it.nrm_index;
          end else if (corner_cnt >= 2) begin
            pending_vertices.push_back(lookup_vertex(first_p, first_n, 1'b0));
            pending_vertices.push_back(lookup_vertex(prev_p, prev_n, 1'b0));
            pending_vertices.push_back(lookup_vertex(it.pos_index, it.nrm_index, 1'b1));
          end
          prev_p = it.pos_index;
          prev_n = it.nrm_index;
          corner_cnt++;
        end
      end
      default: ;
    endcase
  endtask

  // Sender: presents queued items at the falling edge with random gaps.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (tx_taken) begin
        tx_busy  = 1'b0;
        tx_taken = 1'b0;
      end
      if (!tx_busy && item_feed_q.size() > 0) begin
        if (tx_gap > 0) begin
          tx_gap--;
        end else if (!(item_feed_q[0].wait_drain && pending_vertices.size() != 0)) begin
          tx_cur  = item_feed_q.pop_front();
          tx_busy = 1'b1;
          if (tx_cur.hold_rx) hold_req = 1'b1;
          tx_gap = (item_feed_q.size() > 0) ? $urandom_range(0, item_feed_q[0].max_gap) : 0;
        end
      end
      in_valid_i <= tx_busy;
      if (tx_busy) in_i <= tx_cur.item;
    end
  end

  // Long output hold, counted down on its own.
  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_left = LONG_HOLD;
      hold_req  = 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
    end
  end

  // Receiver: waits a random number of cycles before each vertex transfer.
  always @(negedge clk_i) begin
    if (rx_taken) begin
      rx_taken = 1'b0;
      rx_wait  = rx_calm ? 0 : $urandom_range(0, 5);
      if (($urandom_range(0, 31)) == 0) rx_calm = ($urandom_range(0, 1) != 0);
    end
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
    end else if (rx_wait > 0) begin
      rx_wait--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Monitor: checks vertex transfers, then feeds accepted inputs to the triangulator.
  always @(posedge clk_i) begin : monitor
    out_item_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        rx_taken = 1'b1;
        if (pending_vertices.size() == 0) begin
          report_mismatch($sformatf("unexpected vertex %h", out_o));
        end else begin
          want = pending_vertices.pop_front();
          check_field("vert_x", vertices_checked, out_o.vert_x, want.vert_x);
          check_field("vert_y", vertices_checked, out_o.vert_y, want.vert_y);
          check_field("vert_z", vertices_checked, out_o.vert_z, want.vert_z);
          check_field("norm_x", vertices_checked, out_o.norm_x, want.norm_x);
          check_field("norm_y", vertices_checked, out_o.norm_y, want.norm_y);
          check_field("norm_z", vertices_checked, out_o.norm_z, want.norm_z);
          check_field("last_of_triangle", vertices_checked,
                      COORD_WIDTH'(out_o.last_of_triangle),
                      COORD_WIDTH'(want.last_of_triangle));
          check_field("index_error", vertices_checked, COORD_WIDTH'(out_o.index_error),
                      COORD_WIDTH'(want.index_error));
          vertices_checked++;
        end
      end
      if (in_valid_i && in_stall_o) stall_cycles++;
      if (in_valid_i && !in_stall_o) begin
        assemble_item(in_i);
        tx_taken = 1'b1;
        items_taken++;
      end
    end
  end

  // Random coordinate with the extremes drawn now and then.
  function automatic logic [COORD_WIDTH-1:0] rand_coord();
    case ($urandom_range(0, 7))
      0:       return COORD_MAX;
      1:       return COORD_MIN;
      2:       return '0;
      default: return COORD_WIDTH'($urandom);
    endcase
  endfunction

  function automatic in_item_t make_item(logic [1:0] cmd, bit fs, int unsigned p,
                                         int unsigned n);
    in_item_t it;
    it.cmd        = cmd;
    it.face_start = fs;
    it.coord_x    = rand_coord();
    it.coord_y    = rand_coord();
    it.coord_z    = rand_coord();
    it.pos_index  = IDX_WIDTH'(p);
    it.nrm_index  = IDX_WIDTH'(n);
    return it;
  endfunction

  // Mostly valid indices, sometimes zero, just past the count, or the top value.
  function automatic int unsigned pick_index(int unsigned cnt, bit zero_often);
    if (zero_often && $urandom_range(0, 2) == 0) return 0;
    case ($urandom_range(0, 15))
      0:       return 0;
      1:       return (cnt < MAX_V) ? cnt + 1 : MAX_V;
      2:       return MAX_V;
      default: return (cnt > 0) ? $urandom_range(1, cnt) : 0;
    endcase
  endfunction

  task automatic queue_item(input in_item_t it, input int unsigned gap,
                            input bit drain = 1'b0, input bit hold = 1'b0);
    feed_entry_t e;
    e.item       = it;
    e.max_gap    = gap;
    e.wait_drain = drain;
    e.hold_rx    = hold;
    item_feed_q.push_back(e);
    case (it.cmd)
      CMD_POSITION: begin
        gen_counted++;
        if (gen_pos < MAX_V) gen_pos++;
      end
      CMD_NORMAL: begin
        gen_counted++;
        if (gen_nrm < MAX_V) gen_nrm++;
      end
      CMD_CORNER: begin
        if (it.face_start) gen_corner = 0;
        if (gen_corner < MAX_C) begin
          gen_corner++;
          gen_counted++;
        end
      end
      default: ;
    endcase
  endtask

  task automatic queue_corner(input bit fs, input int unsigned gap,
                              input bit drain = 1'b0, input bit hold = 1'b0);
    queue_item(make_item(CMD_CORNER, fs, pick_index(gen_pos, 1'b0),
                         pick_index(gen_nrm, 1'b1)), gap, drain, hold);
  endtask

  task automatic queue_append(input int unsigned gap);
    queue_item(make_item($urandom_range(0, 1) ? CMD_POSITION : CMD_NORMAL,
                         ($urandom_range(0, 1) != 0), $urandom_range(0, MAX_V),
                         $urandom_range(0, MAX_V)), gap);
  endtask

  // Stimulus and end of run.
  initial begin : stimulus
    in_item_t    it;
    int unsigned start, n_c, kind, gap, k;
    bit          pressure_done;

    pressure_done = 1'b0;

    // Corners before anything is stored; the first lacks face_start.
    queue_item(make_item(CMD_CORNER, 1'b0, 0, 0), 2);
    queue_item(make_item(CMD_CORNER, 1'b0, 1, MAX_V), 2);
    queue_item(make_item(CMD_CORNER, 1'b0, MAX_V, 0), 2);

    // Extreme coordinates into both stores, and an unused command.
    it = make_item(CMD_POSITION, 1'b0, 0, 0);
    it.coord_x = COORD_MAX; it.coord_y = COORD_MIN; it.coord_z = '0;
    queue_item(it, 3);
    it = make_item(CMD_POSITION, 1'b1, MAX_V, MAX_V);
    it.coord_x = COORD_MIN; it.coord_y = COORD_MAX; it.coord_z = '1;
    queue_item(it, 3);
    it = make_item(CMD_NORMAL, 1'b0, 0, 0);
    it.coord_x = COORD_MAX; it.coord_y = COORD_MAX; it.coord_z = COORD_MAX;
    queue_item(it, 3);
    it = make_item(CMD_NORMAL, 1'b1, 0, 0);
    it.coord_x = COORD_MIN; it.coord_y = COORD_MIN; it.coord_z = COORD_MIN;
    queue_item(it, 3);
    queue_item(make_item(CMD_UNUSED, 1'b1, MAX_V, MAX_V), 3);

    // One face through every index case, with an append inside it.
    queue_item(make_item(CMD_CORNER, 1'b1, 1, 1), 1);
    queue_item(make_item(CMD_CORNER, 1'b0, 2, 0), 1);
    queue_item(make_item(CMD_CORNER, 1'b0, 3, 2), 1);
    queue_item(make_item(CMD_POSITION, 1'b0, 0, 0), 1);
    queue_item(make_item(CMD_CORNER, 1'b0, 3, 3), 1);
    queue_item(make_item(CMD_CORNER, 1'b0, 2, 1), 1);
    queue_item(make_item(CMD_CORNER, 1'b0, 0, 0), 1);

    // Random part: seed the stores, then mostly well-formed faces.
    start = gen_counted;
    repeat (12) queue_item(make_item(CMD_POSITION, 1'b0, 0, 0), $urandom_range(0, 5));
    repeat (8) queue_item(make_item(CMD_NORMAL, 1'b0, 0, 0), $urandom_range(0, 5));
    while (gen_counted - start < RANDOM_ITEMS) begin
      gap  = ($urandom_range(0, 3) == 0) ? 0 : 5;
      kind = $urandom_range(0, 9);
      if (!pressure_done && gen_counted - start >= 60) begin
        // Hold the output while a gapless face fills the block.
        pressure_done = 1'b1;
        for (k = 0; k < 12; k++) queue_corner(k == 0, 0, k == 0, k == 0);
      end else if (kind < 2) begin
        repeat ($urandom_range(1, 3)) queue_append(gap);
      end else if (kind < 8) begin
        n_c = ($urandom_range(0, 7) == 0) ? $urandom_range(MAX_C + 1, MAX_C + 4)
                                          : $urandom_range(3, 7);
        for (k = 0; k < n_c; k++) begin
          if (k > 0 && $urandom_range(0, 7) == 0) queue_append(gap);
          queue_corner((k == 0) ? ($urandom_range(0, 7) != 0) : 1'b0, gap);
        end
      end else if (kind == 8) begin
        repeat ($urandom_range(1, 2)) queue_corner(($urandom_range(0, 1) != 0), gap);
      end else if ($urandom_range(0, 1)) begin
        queue_item(make_item(CMD_UNUSED, ($urandom_range(0, 1) != 0),
                             $urandom_range(0, MAX_V), $urandom_range(0, MAX_V)), gap);
      end else begin
        queue_corner(1'b0, gap);
      end
    end

    // Corners with indices at the top of the range.
    queue_item(make_item(CMD_CORNER, 1'b1, MAX_V, MAX_V), 2);
    queue_item(make_item(CMD_CORNER, 1'b0, MAX_V - 1, 0), 2);
    queue_item(make_item(CMD_CORNER, 1'b0, 1, MAX_V), 2);
    queue_item(make_item(CMD_CORNER, 1'b0, MAX_V, 1), 2);
    repeat (6) queue_corner(1'b0, 5);

    // Reset once, released on a falling edge.
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (item_feed_q.size() != 0 || tx_busy) @(posedge clk_i);
    while (pending_vertices.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Accepted %0d input transfers and checked %0d vertices; input stalled %0d cycles.",
             items_taken, vertices_checked, stall_cycles);
    $display("Covered index errors, over-long faces, a long output hold and top-range indices.");
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("Timeout with %0d vertices outstanding", pending_vertices.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule
